>>> rtl/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

	localparam int KEY_W     = 32;
	localparam int VALUE_W   = 12;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 4;

	localparam logic [CFG_W-1:0] CFG_SLOTS_LOG2_RESET = 4'd10;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd4;

	typedef struct packed {
		logic               kind;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  found_value;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} slot_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic read;
		logic advance;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic match;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/lph_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lph_ram #(
	parameter int WIDTH = 45,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/lph_ctrl.sv
// Controller state machine: clearing pass, request intake, probe sequencing, response hold.
`timescale 1ns / 1ps
`default_nettype none

module lph_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	input  wire lph_pkg::sts_t sts,
	output lph_pkg::cmd_t      cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;
	localparam logic [1:0] S_EVAL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       resolve;
	logic       out_free;

	assign resolve   = sts.empty | sts.match | sts.last;
	assign out_free  = !rsp_valid_q | rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				if (resolve) begin
					if (out_free) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid_q)
		else $error("response not presented after finish");

	a_load_reads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_READ) && cmd.read)
		else $error("accepted request not followed by a slot read");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && sts.clr_last) |=> (state_q == S_IDLE))
		else $error("clearing pass did not end at the last slot");

endmodule

`default_nettype wire

>>> rtl/lph_dp.sv
// Datapath: size register, request registers, probe index and count, slot RAM, response register.
`timescale 1ns / 1ps
`default_nettype none

module lph_dp #(
	parameter int SLOTS = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lph_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire lph_pkg::req_t                   req,
	input  wire lph_pkg::cmd_t                   cmd,
	output lph_pkg::sts_t                        sts,
	output lph_pkg::rsp_t                        rsp
);

	localparam int AW = $clog2(SLOTS);

	logic [lph_pkg::CFG_W-1:0]   slots_log2_q;
	logic [AW-1:0]               clr_q;
	logic                        kind_q;
	logic [lph_pkg::KEY_W-1:0]   key_q;
	logic [lph_pkg::VALUE_W-1:0] val_q;
	logic [AW-1:0]               idx_q;
	logic [AW-1:0]               rem_q;
	lph_pkg::rsp_t               rsp_q;
	logic [4:0]                  lg;
	logic [AW-1:0]               mask;
	lph_pkg::slot_t              slot;
	lph_pkg::slot_t              wslot;
	logic [$bits(lph_pkg::slot_t)-1:0] rd_data;
	logic                        we;
	logic [AW-1:0]               waddr;

	always_comb begin
		lg = {1'b0, slots_log2_q};
		if (lg == 5'd0) begin
			lg = 5'd1;
		end
		if (lg > 5'(AW)) begin
			lg = 5'(AW);
		end
		for (int b = 0; b < AW; b++) begin
			mask[b] = (5'(b) < lg);
		end
	end

	assign slot = lph_pkg::slot_t'(rd_data);

	assign sts.clr_last = (clr_q == {AW{1'b1}});
	assign sts.empty    = !slot.valid;
	assign sts.match    = slot.valid && (slot.key == key_q);
	assign sts.last     = (rem_q == '0);

	assign wslot.valid = !cmd.clear;
	assign wslot.key   = cmd.clear ? '0 : key_q;
	assign wslot.value = cmd.clear ? '0 : val_q;
	assign waddr       = cmd.clear ? clr_q : idx_q;
	assign we          = cmd.clear
		| (cmd.finish && (kind_q == lph_pkg::KIND_INSERT) && (sts.empty || sts.match));

	lph_ram #(
		.WIDTH ($bits(lph_pkg::slot_t)),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wslot),
		.re    (cmd.read),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_log2_q <= lph_pkg::CFG_SLOTS_LOG2_RESET;
			clr_q        <= '0;
		end else begin
			if (cfg_we) begin
				slots_log2_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			key_q  <= req.key;
			val_q  <= req.value_index;
			idx_q  <= req.key[AW-1:0] & mask;
			rem_q  <= mask;
		end else if (cmd.advance) begin
			idx_q <= (idx_q + 1'b1) & mask;
			rem_q <= rem_q - 1'b1;
		end
		if (cmd.finish) begin
			rsp_q.found_value <= '0;
			if (sts.empty) begin
				rsp_q.status <= (kind_q == lph_pkg::KIND_INSERT) ?
					lph_pkg::STATUS_INSERTED : lph_pkg::STATUS_MISS;
			end else if (sts.match) begin
				if (kind_q == lph_pkg::KIND_INSERT) begin
					rsp_q.status <= lph_pkg::STATUS_REPLACED;
				end else begin
					rsp_q.status      <= lph_pkg::STATUS_HIT;
					rsp_q.found_value <= slot.value;
				end
			end else begin
				rsp_q.status <= (kind_q == lph_pkg::KIND_INSERT) ?
					lph_pkg::STATUS_FULL : lph_pkg::STATUS_MISS;
			end
		end
	end

	assign rsp = rsp_q;

	a_advance_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> (rem_q == AW'($past(rem_q) - 1'b1)))
		else $error("probe count did not step on advance");

	a_home_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ((idx_q & ~mask) == '0))
		else $error("home slot outside the slots in use");

	a_finish_resolved: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (sts.empty || sts.match || sts.last))
		else $error("probe finished before an empty, matching or last slot");

endmodule

`default_nettype wire

>>> rtl/linear_probe_hash_table.sv
// Top level of the open-addressed, linearly probed hash table.
`timescale 1ns / 1ps
`default_nettype none

// Hash table of SLOTS entries (key, value index, valid) in one RAM. After reset a clearing
// pass writes every slot empty, one slot per cycle, through all SLOTS slots (1024 by default);
// req_ready stays low until it ends. A request then probes from one up to all of the slots in
// use: each probe is a RAM read followed by a compare, and the insert write lands in the final
// compare, which waits until the output register is free. The response waits in an output
// register, so the next request is taken while it is not yet collected.
// cfg_wdata sets log2 of the slots in use (0 acts as 1, values above log2(SLOTS) use SLOTS);
// write it only while no request is in flight. Resizing keeps the slot contents in place.
module linear_probe_hash_table #(
	parameter int SLOTS = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [lph_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire lph_pkg::req_t             req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output lph_pkg::rsp_t                  rsp
);

	lph_pkg::cmd_t cmd;
	lph_pkg::sts_t sts;

	lph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lph_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the linear probing hash table: predicted responses, random traffic.
`timescale 1ns / 1ps

module testbench;

	localparam int          SLOTS        = 1024;
	localparam int          PHASES       = 12;
	localparam int          PHASE_ITEMS  = 104;
	localparam int          SETTLE       = 2100;
	localparam int unsigned CYCLE_LIMIT  = 12_000_000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	class probe_table;
		logic [lph_pkg::CFG_W-1:0]   size_log2;
		bit                          slot_valid [SLOTS];
		logic [lph_pkg::KEY_W-1:0]   slot_key   [SLOTS];
		logic [lph_pkg::VALUE_W-1:0] slot_value [SLOTS];
		lph_pkg::rsp_t               expected_rsp [$];
		int                          mismatches;

		function new();
			size_log2 = lph_pkg::CFG_SLOTS_LOG2_RESET;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			mismatches = 0;
		endfunction

		function void resize(logic [lph_pkg::CFG_W-1:0] v);
			size_log2 = v;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		function void note_request(lph_pkg::req_t r);
			lph_pkg::rsp_t e;
			int unsigned   lg, n, mask, idx, p;
			bit            done;
			lg = size_log2;
			if (lg < 1) lg = 1;
			n = 1 << lg;
			if (n > SLOTS) n = SLOTS;
			mask = n - 1;
			idx = r.key & mask;
			e.status = (r.kind == lph_pkg::KIND_INSERT) ?
				lph_pkg::STATUS_FULL : lph_pkg::STATUS_MISS;
			e.found_value = '0;
			done = 1'b0;
			for (p = 0; p < n && !done; p++) begin
				if (!slot_valid[idx]) begin
					if (r.kind == lph_pkg::KIND_INSERT) begin
						slot_valid[idx] = 1'b1;
						slot_key[idx] = r.key;
						slot_value[idx] = r.value_index;
						e.status = lph_pkg::STATUS_INSERTED;
					end else begin
						e.status = lph_pkg::STATUS_MISS;
					end
					done = 1'b1;
				end else if (slot_key[idx] == r.key) begin
					if (r.kind == lph_pkg::KIND_INSERT) begin
						slot_value[idx] = r.value_index;
						e.status = lph_pkg::STATUS_REPLACED;
					end else begin
						e.status = lph_pkg::STATUS_HIT;
						e.found_value = slot_value[idx];
					end
					done = 1'b1;
				end else begin
					idx = (idx + 1) & mask;
				end
			end
			expected_rsp.push_back(e);
		endfunction

		function void check_response(lph_pkg::rsp_t r);
			lph_pkg::rsp_t e;
			if (expected_rsp.size() == 0) begin
				$error("response with no request outstanding: status %0d found_value %0d",
					r.status, r.found_value);
				mismatches++;
				return;
			end
			e = expected_rsp.pop_front();
			if (r.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, r.status);
				mismatches++;
			end
			if (r.found_value !== e.found_value) begin
				$error("found_value: expected %0d, got %0d", e.found_value, r.found_value);
				mismatches++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [lph_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	lph_pkg::req_t             req       = '0;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	lph_pkg::rsp_t             rsp;

	probe_table                table_sb;
	logic [lph_pkg::KEY_W-1:0] known_keys [$];
	int unsigned               send_idle_pct = 0;
	int unsigned               rsp_stall_pct = 0;
	int unsigned               cycle_count   = 0;
	int unsigned               phase_log2 [PHASES] = '{3, 5, 10, 15, 1, 7, 2, 12, 10, 4, 9, 6};

	linear_probe_hash_table #(
		.SLOTS(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
				table_sb.check_response(rsp);
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	function automatic lph_pkg::req_t make_req(logic kind, logic [lph_pkg::KEY_W-1:0] key,
			logic [lph_pkg::VALUE_W-1:0] value_index);
		lph_pkg::req_t r;
		r.kind = kind;
		r.key = key;
		r.value_index = value_index;
		return r;
	endfunction

	function automatic lph_pkg::req_t random_request();
		lph_pkg::req_t r;
		int unsigned   pick;
		r.kind = ($urandom_range(99) < 45) ? lph_pkg::KIND_INSERT : lph_pkg::KIND_LOOKUP;
		r.value_index = lph_pkg::VALUE_W'($urandom());
		pick = $urandom_range(99);
		if (known_keys.size() != 0
				&& pick < ((r.kind == lph_pkg::KIND_INSERT) ? 25 : 60))
			r.key = known_keys[$urandom_range(known_keys.size() - 1)];
		else if (pick < 80)
			r.key = $urandom();
		else
			r.key = ($urandom() << 4) | $urandom_range(15);
		return r;
	endfunction

	task automatic send_request(input lph_pkg::req_t r);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_ready !== 1'b1);
		table_sb.note_request(r);
		if (r.kind == lph_pkg::KIND_INSERT) known_keys.push_back(r.key);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (table_sb.pending() != 0);
	endtask

	task automatic set_slots_log2(input logic [lph_pkg::CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_sb.resize(v);
	endtask

	initial begin
		idle_mode_t mode;
		table_sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two slots: fill, replace, full sweep on insert and lookup
		set_slots_log2(4'd0);
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h0000_0000, 12'hFFF));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h0000_0000, 12'h000));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h0000_0000, 12'hFFF));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h0000_0002, 12'h000));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'hFFFF_FFFF, 12'h5A5));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h0000_0004, 12'h3C3));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h0000_0004, 12'h000));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 12'h000));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'hFFFF_FFFF, 12'hFFF));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h0000_0001, 12'h000));

		// grow: old entries stay in place, a key can be stored twice
		req_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		set_slots_log2(4'd2);
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 12'h000));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'hFFFF_FFFF, 12'h123));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 12'h000));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h0000_0000, 12'h000));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h0000_0006, 12'h001));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h0000_000A, 12'h002));

		// oversized setting clamps to the physical slot count
		req_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		set_slots_log2(4'd15);
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h8000_0003, 12'h800));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h8000_0003, 12'h000));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 12'hFFF));
		send_request(make_req(lph_pkg::KIND_INSERT, 32'h7FFF_FFFF, 12'h7FF));
		send_request(make_req(lph_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 12'h000));

		for (int ph = 0; ph < PHASES; ph++) begin
			req_valid <= 1'b0;
			wait_drained();
			repeat (8) @(posedge clk);
			set_slots_log2(lph_pkg::CFG_W'(phase_log2[ph]));
			mode = idle_mode_t'(ph % 4);
			case (mode)
				IDLE_NONE: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				IDLE_SENDER: begin
					send_idle_pct = 78;
					rsp_stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct = 0;
					rsp_stall_pct = 78;
				end
				default: begin
					send_idle_pct = 17;
					rsp_stall_pct = 17;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_request(random_request());
				// one time in 50, hold off until the table has answered everything
				if ($urandom_range(49) == 0) begin
					req_valid <= 1'b0;
					wait_drained();
				end
			end
		end

		req_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (table_sb.mismatches == 0 && table_sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/lph_ctrl.sv
rtl/lph_dp.sv
rtl/linear_probe_hash_table.sv
dv/testbench.sv
